// ===== rtl/fenwick_prefix_sum_tree_core_assert.svh =====
// Assertion macros for the checker file of this block.
`ifndef FENWICK_PREFIX_SUM_TREE_CORE_ASSERT_SVH
`define FENWICK_PREFIX_SUM_TREE_CORE_ASSERT_SVH

// Next-cycle implication, switched off while reset is asserted.
`define FPST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fpst assertion failed");

// Next-cycle implication that also holds across reset.
`define FPST_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("fpst assertion failed");

`endif

// ===== rtl/fpst_pkg.sv =====
`default_nettype none

package fpst_pkg;

  localparam int POS_W   = 11;
  localparam int DELTA_W = 16;
  localparam int SUM_W   = 32;
  localparam int SIZE_W  = 11;
  // Walk index: an upward walk may step to twice the active size.
  localparam int IDX_W   = 12;

  localparam int DEF_MAX_SIZE = 1024;

  localparam logic [SIZE_W-1:0] ACTIVE_SIZE_RST = 11'd1024;

  localparam logic MODE_ADD   = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic start;
    logic step;
    logic clr;
    logic out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic walk_more;
    logic query;
    logic clear_last;
  } ctl_sts_t;

endpackage

`default_nettype wire

// ===== rtl/fpst_if.sv =====
`default_nettype none

interface fpst_in_if;
  logic                                valid;
  logic                                ready;
  logic                                mode;
  logic [fpst_pkg::POS_W-1:0]          position;
  logic signed [fpst_pkg::DELTA_W-1:0] delta;

  modport source (output valid, output mode, output position, output delta, input ready);
  modport sink   (input valid, input mode, input position, input delta, output ready);
endinterface

interface fpst_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [fpst_pkg::SUM_W-1:0] prefix_total;

  modport source (output valid, output prefix_total, input ready);
  modport sink   (input valid, input prefix_total, output ready);
endinterface

`default_nettype wire

// ===== rtl/fpst_ram.sv =====
`default_nettype none

module fpst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/fpst_datapath.sv =====
`default_nettype none

module fpst_datapath #(
  parameter int MAX_SIZE = fpst_pkg::DEF_MAX_SIZE
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [fpst_pkg::SIZE_W-1:0]         cfg_wdata,
  input  wire logic                                in_mode,
  input  wire logic [fpst_pkg::POS_W-1:0]          in_position,
  input  wire logic signed [fpst_pkg::DELTA_W-1:0] in_delta,
  input  wire fpst_pkg::ctl_cmd_t                  cmd,
  output fpst_pkg::ctl_sts_t                       sts,
  output logic signed [fpst_pkg::SUM_W-1:0]        prefix_total
);

  localparam int AW    = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int IDX_W = fpst_pkg::IDX_W;
  localparam int EXT_W = (AW > IDX_W) ? AW : IDX_W;
  localparam int SUM_W = fpst_pkg::SUM_W;

  logic [fpst_pkg::SIZE_W-1:0] active_size_r;
  logic                        mode_r;
  logic [IDX_W-1:0]            idx_r;
  logic [SUM_W-1:0]            delta_r;
  logic                        rd_valid_r;
  logic [AW-1:0]               wb_addr_r;
  logic [SUM_W-1:0]            total_r;
  logic [AW-1:0]               clr_addr_r;
  logic [SUM_W-1:0]            prefix_total_r;

  logic [IDX_W-1:0] limit;
  logic [IDX_W-1:0] pos_sat;
  logic [IDX_W-1:0] low_bit;
  logic [IDX_W-1:0] idx_nxt;
  logic [EXT_W-1:0] idx_ext;
  logic [AW-1:0]    rd_addr;
  logic             walk_more;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [SUM_W-1:0] ram_wdata;
  logic [SUM_W-1:0] ram_rdata;

  always_comb begin
    if (32'(active_size_r) > 32'(MAX_SIZE)) begin
      limit = IDX_W'(MAX_SIZE);
    end else begin
      limit = IDX_W'(active_size_r);
    end
    if (32'(in_position) > 32'(MAX_SIZE)) begin
      pos_sat = IDX_W'(MAX_SIZE);
    end else begin
      pos_sat = IDX_W'(in_position);
    end
  end

  assign low_bit = idx_r & (~idx_r + IDX_W'(1));
  assign idx_ext = EXT_W'(idx_r) - EXT_W'(1);
  assign rd_addr = idx_ext[AW-1:0];

  always_comb begin
    if (mode_r == fpst_pkg::MODE_QUERY) begin
      walk_more = (idx_r != '0);
      idx_nxt   = idx_r - low_bit;
    end else begin
      walk_more = (idx_r != '0) && (idx_r <= limit);
      idx_nxt   = idx_r + low_bit;
    end
  end

  assign ram_we    = cmd.clr || (rd_valid_r && (mode_r == fpst_pkg::MODE_ADD));
  assign ram_waddr = cmd.clr ? clr_addr_r : wb_addr_r;
  assign ram_wdata = cmd.clr ? '0 : (ram_rdata + delta_r);

  fpst_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_SIZE)
  ) u_nodes (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.step),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_size_r <= fpst_pkg::ACTIVE_SIZE_RST;
      clr_addr_r    <= '0;
      rd_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        active_size_r <= cfg_wdata;
      end
      if (cmd.clr) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
      rd_valid_r <= cmd.step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      mode_r  <= in_mode;
      idx_r   <= (in_mode == fpst_pkg::MODE_QUERY) ? pos_sat : IDX_W'(in_position);
      delta_r <= SUM_W'(in_delta);
      total_r <= '0;
    end else begin
      if (cmd.step) begin
        idx_r <= idx_nxt;
      end
      if (rd_valid_r && (mode_r == fpst_pkg::MODE_QUERY)) begin
        total_r <= total_r + ram_rdata;
      end
    end
    if (cmd.step) begin
      wb_addr_r <= rd_addr;
    end
    if (cmd.out_load) begin
      prefix_total_r <= total_r;
    end
  end

  assign sts.walk_more  = walk_more;
  assign sts.query      = (mode_r == fpst_pkg::MODE_QUERY);
  assign sts.clear_last = (clr_addr_r == AW'(MAX_SIZE - 1));
  assign prefix_total   = prefix_total_r;

endmodule

`default_nettype wire

// ===== rtl/fpst_ctrl.sv =====
`default_nettype none

module fpst_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire fpst_pkg::ctl_sts_t sts,
  output fpst_pkg::ctl_cmd_t      cmd
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r, in_ready_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    in_ready_nxt  = in_ready_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clear_last) begin
          state_nxt    = ST_IDLE;
          in_ready_nxt = 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.start    = 1'b1;
          state_nxt    = ST_WALK;
          in_ready_nxt = 1'b0;
        end
      end
      ST_WALK: begin
        if (sts.walk_more) begin
          cmd.step = 1'b1;
        end else if (sts.query) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt    = ST_IDLE;
          in_ready_nxt = 1'b1;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          in_ready_nxt  = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      in_ready_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_ready_r  <= in_ready_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = in_ready_r;
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ===== rtl/fenwick_prefix_sum_tree_core.sv =====
// Binary indexed tree of MAX_SIZE 32-bit nodes that takes one request at a time: an add request
// walks upward from its position, adding the sign-extended delta to each node up to the active
// size, and a query request walks downward, summing nodes, and returns one wrapped prefix total.
// Each walk step is one read of the single node memory, followed in the next cycle by the
// write-back or accumulation, overlapped with the next read. With 1024 nodes an add visits at
// most 11 nodes and a query at most 10. After reset the node memory is cleared one entry per
// cycle, so the block accepts no request until every entry is cleared; the active size register
// may be written at any time it is idle.
`default_nettype none

module fenwick_prefix_sum_tree_core #(
  parameter int MAX_SIZE = fpst_pkg::DEF_MAX_SIZE
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [fpst_pkg::SIZE_W-1:0] cfg_wdata,
  fpst_in_if.sink                          in_ch,
  fpst_out_if.source                       out_ch
);

  fpst_pkg::ctl_cmd_t cmd;
  fpst_pkg::ctl_sts_t sts;

  fpst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fpst_datapath #(
    .MAX_SIZE (MAX_SIZE)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_mode      (in_ch.mode),
    .in_position  (in_ch.position),
    .in_delta     (in_ch.delta),
    .cmd          (cmd),
    .sts          (sts),
    .prefix_total (out_ch.prefix_total)
  );

endmodule

`default_nettype wire

// ===== rtl/fpst_checker.sv =====
`default_nettype none

`include "fenwick_prefix_sum_tree_core_assert.svh"

module fpst_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_valid,
  input wire logic                              in_ready,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic signed [fpst_pkg::SUM_W-1:0] out_prefix_total
);

  // The node memory is being cleared straight after reset.
  `FPST_ASSERT_NEXT_ALWAYS(a_no_ready_after_reset, clk, !rst_n, !in_ready)

  // Only one request is worked on at a time.
  `FPST_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready)

  `FPST_ASSERT_NEXT(a_out_valid_held, clk, rst_n, out_valid && !out_ready, out_valid)

  `FPST_ASSERT_NEXT(a_out_total_held, clk, rst_n, out_valid && !out_ready,
                    $stable(out_prefix_total))

endmodule

bind fenwick_prefix_sum_tree_core fpst_checker u_fpst_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_prefix_total (out_ch.prefix_total)
);

`default_nettype wire

// ===== tb/sv/fenwick_prefix_sum_tree_core_tb.sv =====
module fenwick_prefix_sum_tree_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_NODES     = fpst_pkg::DEF_MAX_SIZE;
  localparam int SETTLE_CYCLES = 24;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PHASE_ITEMS   = 285;

  class prefix_sum_scoreboard;
    bit [fpst_pkg::SUM_W-1:0]          node_sum [1:MAX_NODES];
    int unsigned                       size_limit = MAX_NODES;
    logic signed [fpst_pkg::SUM_W-1:0] expected_totals [$];
    int unsigned                       errors;
    int unsigned                       reported;

    function void set_active_size(logic [fpst_pkg::SIZE_W-1:0] value);
      size_limit = (32'(value) > MAX_NODES) ? MAX_NODES : 32'(value);
    endfunction

    function int unsigned pending();
      return expected_totals.size();
    endfunction

    function void note_request(logic mode, logic [fpst_pkg::POS_W-1:0] position,
                               logic signed [fpst_pkg::DELTA_W-1:0] delta);
      int unsigned              idx;
      bit [fpst_pkg::SUM_W-1:0] amount;
      bit [fpst_pkg::SUM_W-1:0] total;
      if (mode == fpst_pkg::MODE_ADD) begin
        if (position == 0) return;
        amount = {{(fpst_pkg::SUM_W-fpst_pkg::DELTA_W){delta[fpst_pkg::DELTA_W-1]}}, delta};
        idx = 32'(position);
        while (idx <= size_limit) begin
          node_sum[idx] += amount;
          idx += idx & (~idx + 1);
        end
      end else begin
        idx = (32'(position) > MAX_NODES) ? MAX_NODES : 32'(position);
        total = '0;
        while (idx > 0) begin
          total += node_sum[idx];
          idx -= idx & (~idx + 1);
        end
        expected_totals.push_back(total);
      end
    endfunction

    function void check_total(logic signed [fpst_pkg::SUM_W-1:0] actual);
      logic signed [fpst_pkg::SUM_W-1:0] want;
      if (expected_totals.size() == 0) begin
        errors++;
        if (reported < 10) begin
          reported++;
          $display("prefix total %0d returned with no query request pending", actual);
        end
        return;
      end
      want = expected_totals.pop_front();
      if (actual !== want) begin
        errors++;
        if (reported < 10) begin
          reported++;
          $display("prefix total mismatch: expected %0d, got %0d", want, actual);
        end
      end
    endfunction
  endclass

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         cfg_we;
  logic [fpst_pkg::SIZE_W-1:0]  cfg_wdata;
  logic [10:0]                  rx_phase = '0;
  int unsigned                  cycle_count = 0;
  int unsigned                  burst_left = 1;
  int unsigned                  gap_left = 0;
  prefix_sum_scoreboard         totals_board;

  fpst_in_if  in_ch ();
  fpst_out_if out_ch ();

  fenwick_prefix_sum_tree_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // The receiver cycles through free running, random stalls, alternate cycles and long stalls.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
      totals_board.check_total(out_ch.prefix_total);
    rx_phase <= rx_phase + 11'd1;
    case (rx_phase[9:8])
      2'd0: out_ch.ready <= 1'b1;
      2'd1: out_ch.ready <= ($urandom_range(0, 3) != 0);
      2'd2: out_ch.ready <= rx_phase[0];
      default: out_ch.ready <= (rx_phase[4:0] >= 5'd20);
    endcase
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) return 0;
    if (r < 8) return $urandom_range(1, 3);
    return $urandom_range(4, 12);
  endfunction

  task automatic send_request(input logic mode, input logic [fpst_pkg::POS_W-1:0] position,
                              input logic signed [fpst_pkg::DELTA_W-1:0] delta);
    if (gap_left > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap_left) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.mode     <= mode;
    in_ch.position <= position;
    in_ch.delta    <= delta;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    totals_board.note_request(mode, position, delta);
    burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap_left   = pick_gap();
    end else begin
      gap_left = 0;
    end
  endtask

  // An add request gives no result, so with settle set a pause follows before the register may change.
  task automatic drain_totals(input bit settle);
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (totals_board.pending() != 0);
    if (settle) repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_active_size(input logic [fpst_pkg::SIZE_W-1:0] value);
    drain_totals(1'b1);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    totals_board.set_active_size(value);
  endtask

  task automatic random_request(output logic mode, output logic [fpst_pkg::POS_W-1:0] position,
                                output logic signed [fpst_pkg::DELTA_W-1:0] delta);
    int unsigned lim;
    int unsigned pick;
    lim  = totals_board.size_limit;
    mode = ($urandom_range(0, 99) < 45) ? fpst_pkg::MODE_QUERY : fpst_pkg::MODE_ADD;
    pick = $urandom_range(0, 99);
    if (pick < 75 && lim > 0) position = fpst_pkg::POS_W'($urandom_range(1, lim));
    else if (pick < 85) position = fpst_pkg::POS_W'(lim);
    else if (pick < 90) position = '0;
    else position = fpst_pkg::POS_W'($urandom_range(0, 2047));
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      delta = fpst_pkg::DELTA_W'($urandom_range(0, 65535));
    end else if (pick < 75) begin
      case ($urandom_range(0, 3))
        0: delta = -16'sd32768;
        1: delta = 16'sd32767;
        2: delta = -16'sd1;
        default: delta = '0;
      endcase
    end else begin
      delta = fpst_pkg::DELTA_W'($urandom_range(0, 16) - 8);
    end
  endtask

  initial begin
    logic                               mode;
    logic [fpst_pkg::POS_W-1:0]          position;
    logic signed [fpst_pkg::DELTA_W-1:0] delta;
    logic [fpst_pkg::SIZE_W-1:0]         phase_size;
    int unsigned                        failures;

    in_ch.valid    = 1'b0;
    in_ch.mode     = fpst_pkg::MODE_ADD;
    in_ch.position = '0;
    in_ch.delta    = '0;
    out_ch.ready   = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    rst_n          = 1'b0;
    totals_board   = new;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    send_request(fpst_pkg::MODE_QUERY, 11'd0, 16'sd0);
    send_request(fpst_pkg::MODE_QUERY, 11'd1024, 16'sd0);
    send_request(fpst_pkg::MODE_ADD, 11'd0, -16'sd32768);
    send_request(fpst_pkg::MODE_ADD, 11'd1, 16'sd32767);
    send_request(fpst_pkg::MODE_ADD, 11'd1024, -16'sd32768);
    send_request(fpst_pkg::MODE_ADD, 11'd1023, -16'sd1);
    send_request(fpst_pkg::MODE_ADD, 11'd512, 16'sd1);
    send_request(fpst_pkg::MODE_ADD, 11'd2047, 16'sd100);
    send_request(fpst_pkg::MODE_ADD, 11'd1025, 16'sd5);
    send_request(fpst_pkg::MODE_QUERY, 11'd1, 16'sd0);
    send_request(fpst_pkg::MODE_QUERY, 11'd511, 16'sd0);
    send_request(fpst_pkg::MODE_QUERY, 11'd512, 16'sd0);
    send_request(fpst_pkg::MODE_QUERY, 11'd1023, 16'sd0);
    send_request(fpst_pkg::MODE_QUERY, 11'd1025, -16'sd1);
    send_request(fpst_pkg::MODE_QUERY, 11'd2047, 16'sd0);

    write_active_size(11'd1);
    send_request(fpst_pkg::MODE_ADD, 11'd1, 16'sd7);
    send_request(fpst_pkg::MODE_ADD, 11'd2, 16'sd9);
    send_request(fpst_pkg::MODE_QUERY, 11'd2, 16'sd0);
    send_request(fpst_pkg::MODE_QUERY, 11'd1024, 16'sd0);

    write_active_size(11'd0);
    send_request(fpst_pkg::MODE_ADD, 11'd1, 16'sd3);
    send_request(fpst_pkg::MODE_QUERY, 11'd1024, 16'sd0);

    write_active_size(11'd2047);
    send_request(fpst_pkg::MODE_ADD, 11'd1024, -16'sd5);
    send_request(fpst_pkg::MODE_QUERY, 11'd2047, 16'sd0);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: phase_size = 11'd1024;
        1: phase_size = fpst_pkg::SIZE_W'($urandom_range(2, 1023));
        2: phase_size = 11'd2047;
        3: phase_size = fpst_pkg::SIZE_W'($urandom_range(1, 64));
        4: phase_size = 11'd1024;
        default: phase_size = fpst_pkg::SIZE_W'($urandom_range(512, 1023));
      endcase
      write_active_size(phase_size);
      repeat (PHASE_ITEMS) begin
        random_request(mode, position, delta);
        send_request(mode, position, delta);
        if ($urandom_range(0, 149) == 0) drain_totals(1'b0);
      end
    end

    drain_totals(1'b1);
    failures = totals_board.errors + totals_board.pending();
    if (failures == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end
endmodule
